### hdl/command_line_json_framer_unit_defines.svh
// Assertion macros for the command line JSON framer.
// Included by the RTL files that carry concurrent assertions; no dependencies.
`ifndef COMMAND_LINE_JSON_FRAMER_UNIT_DEFINES_SVH
`define COMMAND_LINE_JSON_FRAMER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CLJF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CLJF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/cljf_pkg.sv
// Package for the command line JSON framer: sizes, character codes,
// command kind and sequencer state types. No dependencies.
package cljf_pkg;

  localparam int unsigned MAX_COMMAND_BYTES = 32;
  localparam int unsigned DEPTH_W           = 5;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_OPEN  = 8'h7B;
  localparam logic [7:0] CH_CLOSE = 8'h7D;

  typedef enum logic [1:0] {
    KIND_REGULAR = 2'd0,
    KIND_JSON    = 2'd1,
    KIND_UNKNOWN = 2'd2
  } kind_e;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_e;

endpackage

### hdl/command_line_json_framer_unit.sv
// Command line JSON framer: frames terminal bytes into regular or JSON commands.
// Depends on cljf_pkg and command_line_json_framer_unit_defines.svh.
//
//  channel   | direction | tdata            | tuser    | tlast
//  s_axis    | in        | [7:0] rx_byte    | -        | -
//  m_axis    | out       | [7:0] out_byte   | is_json  | last (trailing LF)
//
// An accepted input byte other than BS, LF or CR is written into the command memory.
// A finished command of N bytes drains N+1 results, one per cycle while the output
// is not stalled, through the single read port of the memory.
// Input is held off from command completion until the trailing LF is read.
// Reset is asynchronous and active low; the memory is not cleared.
// Output stalls hold the read stage and the output register in place.
`include "command_line_json_framer_unit_defines.svh"

module command_line_json_framer_unit #(
  parameter int unsigned MAX_COMMAND_BYTES = cljf_pkg::MAX_COMMAND_BYTES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // [7:0] rx_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,  // [7:0] out_byte
  output logic       m_axis_tuser_o,  // [0] is_json
  output logic       m_axis_tlast_o
);

  localparam int unsigned CW = $clog2(MAX_COMMAND_BYTES + 1);
  localparam int unsigned AW = $clog2(MAX_COMMAND_BYTES);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_COMMAND_BYTES);
  localparam int unsigned DW = cljf_pkg::DEPTH_W;

  logic [7:0] cmd_mem_q [MAX_COMMAND_BYTES];

  cljf_pkg::state_e state_q, state_d;
  cljf_pkg::kind_e  kind_q, kind_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [DW-1:0]    depth_q, depth_d;
  logic [CW-1:0]    drain_cnt_q, drain_cnt_d;
  logic             drain_json_q, drain_json_d;
  logic [CW-1:0]    rd_idx_q, rd_idx_d;

  logic             rdv_q, rdv_d;
  logic             rd_lf_q, rd_lf_d;
  logic             rd_json_q, rd_json_d;
  logic [7:0]       mem_rd_q;

  logic             out_vld_q, out_vld_d;
  logic [7:0]       out_byte_q, out_byte_d;
  logic             out_json_q, out_json_d;
  logic             out_last_q, out_last_d;

  logic             in_acc;
  logic             wr_en;
  logic             rd_en;
  logic             issue;
  logic             load;
  logic [CW-1:0]    cnt_inc;
  logic [DW-1:0]    depth_dec;

  assign s_axis_tready_o = (state_q == cljf_pkg::ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign cnt_inc         = cnt_q + CW'(1);
  assign depth_dec       = depth_q - DW'(1);

  assign load  = rdv_q && (!out_vld_q || m_axis_tready_i);
  assign issue = (state_q == cljf_pkg::ST_DRAIN) && (!rdv_q || load);
  assign rd_en = issue && (rd_idx_q != drain_cnt_q);

  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    cnt_d        = cnt_q;
    depth_d      = depth_q;
    drain_cnt_d  = drain_cnt_q;
    drain_json_d = drain_json_q;
    rd_idx_d     = rd_idx_q;
    wr_en        = 1'b0;

    if (in_acc) begin
      if (s_axis_tdata_i == cljf_pkg::CH_BS) begin
        if (cnt_q != '0) begin
          cnt_d = cnt_q - CW'(1);
        end
      end else if (s_axis_tdata_i inside {cljf_pkg::CH_LF, cljf_pkg::CH_CR}) begin
        if (cnt_q != '0 && kind_q == cljf_pkg::KIND_REGULAR) begin
          state_d      = cljf_pkg::ST_DRAIN;
          drain_cnt_d  = cnt_q;
          drain_json_d = 1'b0;
          rd_idx_d     = '0;
          cnt_d        = '0;
          kind_d       = cljf_pkg::KIND_UNKNOWN;
        end
      end else begin
        wr_en = 1'b1;
        // drop the command once the store fills
        if (cnt_inc == MaxCnt) begin
          cnt_d  = '0;
          kind_d = cljf_pkg::KIND_UNKNOWN;
        end else begin
          cnt_d = cnt_inc;
        end
        case (kind_q)
          cljf_pkg::KIND_REGULAR: begin
          end
          cljf_pkg::KIND_JSON: begin
            if (s_axis_tdata_i == cljf_pkg::CH_OPEN) begin
              depth_d = depth_q + DW'(1);
            end else if (s_axis_tdata_i == cljf_pkg::CH_CLOSE) begin
              depth_d = depth_dec;
              if (depth_dec == '0) begin
                state_d      = cljf_pkg::ST_DRAIN;
                drain_cnt_d  = cnt_inc;
                drain_json_d = 1'b1;
                rd_idx_d     = '0;
                cnt_d        = '0;
                kind_d       = cljf_pkg::KIND_UNKNOWN;
              end
            end
          end
          default: begin
            // first byte fixes the kind, unless the store filled on it
            if (cnt_inc != MaxCnt) begin
              if (s_axis_tdata_i == cljf_pkg::CH_OPEN) begin
                kind_d  = cljf_pkg::KIND_JSON;
                depth_d = DW'(1);
              end else begin
                kind_d = cljf_pkg::KIND_REGULAR;
              end
            end else if (s_axis_tdata_i == cljf_pkg::CH_OPEN) begin
              depth_d = DW'(1);
            end
          end
        endcase
      end
    end

    if (issue) begin
      rd_idx_d = rd_idx_q + CW'(1);
      // trailing LF issued: release the input side
      if (rd_idx_q == drain_cnt_q) begin
        state_d = cljf_pkg::ST_IDLE;
      end
    end
  end

  always_comb begin
    rdv_d     = rdv_q;
    rd_lf_d   = rd_lf_q;
    rd_json_d = rd_json_q;
    if (issue) begin
      rdv_d     = 1'b1;
      rd_lf_d   = (rd_idx_q == drain_cnt_q);
      rd_json_d = drain_json_q;
    end else if (load) begin
      rdv_d = 1'b0;
    end

    out_vld_d  = out_vld_q && !m_axis_tready_i;
    out_byte_d = out_byte_q;
    out_json_d = out_json_q;
    out_last_d = out_last_q;
    if (load) begin
      out_vld_d  = 1'b1;
      out_byte_d = rd_lf_q ? cljf_pkg::CH_LF : mem_rd_q;
      out_json_d = rd_json_q;
      out_last_d = rd_lf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= cljf_pkg::ST_IDLE;
      kind_q       <= cljf_pkg::KIND_UNKNOWN;
      cnt_q        <= '0;
      depth_q      <= '0;
      drain_cnt_q  <= '0;
      drain_json_q <= 1'b0;
      rd_idx_q     <= '0;
      rdv_q        <= 1'b0;
      rd_lf_q      <= 1'b0;
      rd_json_q    <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      kind_q       <= kind_d;
      cnt_q        <= cnt_d;
      depth_q      <= depth_d;
      drain_cnt_q  <= drain_cnt_d;
      drain_json_q <= drain_json_d;
      rd_idx_q     <= rd_idx_d;
      rdv_q        <= rdv_d;
      rd_lf_q      <= rd_lf_d;
      rd_json_q    <= rd_json_d;
      out_vld_q    <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_json_q <= out_json_d;
    out_last_q <= out_last_d;
  end

  // command memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      cmd_mem_q[cnt_q[AW-1:0]] <= s_axis_tdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      mem_rd_q <= cmd_mem_q[rd_idx_q[AW-1:0]];
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tuser_o  = out_json_q;
  assign m_axis_tlast_o  = out_last_q;

  `CLJF_ASSERT_IMPL(a_cnt_below_max, clk_i, rst_ni, 1'b1, cnt_q < MaxCnt, "stored count reached store size")
  `CLJF_ASSERT_IMPL(a_unknown_empty, clk_i, rst_ni, kind_q == cljf_pkg::KIND_UNKNOWN, cnt_q == '0, "unknown kind with stored bytes")
  `CLJF_ASSERT_IMPL(a_issue_in_range, clk_i, rst_ni, issue, rd_idx_q <= drain_cnt_q, "read issued past command end")
  `CLJF_ASSERT_NEXT(a_rd_stage_holds, clk_i, rst_ni, rdv_q && !load, rdv_q && $stable(mem_rd_q), "read stage lost data under stall")
  `CLJF_ASSERT_IMPL(a_last_is_lf, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tlast_o, m_axis_tdata_o == cljf_pkg::CH_LF, "last byte is not LF")

endmodule
